>>> rtl/bfoc_pkg.sv
// ----------------------------------------------------------------------------
// bfoc_pkg
// Shared types and constants for the barometric first-order compensation block.
// ----------------------------------------------------------------------------
package bfoc_pkg;

   // Field widths
   localparam int CalWidth    = 16;
   localparam int RawWidth    = 24;
   localparam int TempOutWidth = 18;
   localparam int PresOutWidth = 24;

   // Intermediate widths
   localparam int DtWidth     = 25;   // temperature_raw - ref * 2^8
   localparam int TcProdWidth = 42;   // dT times a 16-bit coefficient
   localparam int OffWidth    = 37;
   localparam int SensWidth   = 36;
   localparam int SensLoWidth = 18;   // unsigned low slice of SENS
   localparam int SensHiWidth = SensWidth - SensLoWidth;
   localparam int PlWidth     = RawWidth + SensLoWidth;
   localparam int PhWidth     = RawWidth + 1 + SensHiWidth;
   localparam int MulWidth    = 61;   // full pressure * SENS product
   localparam int ScaledWidth = 40;   // product after the 2^21 scaling

   // Scaling constants
   localparam int TempBase     = 2000;
   localparam int RefShift     = 8;
   localparam int OffShift     = 17;
   localparam int OffTcShift   = 6;
   localparam int SensShift    = 16;
   localparam int SensTcShift  = 7;
   localparam int TempShift    = 23;
   localparam int ProdShift    = 21;
   localparam int PresShift    = 15;

   localparam int CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SENS        = 3'd0,
      CSR_OFFSET      = 3'd1,
      CSR_SENS_TEMP   = 3'd2,
      CSR_OFFSET_TEMP = 3'd3,
      CSR_REF_TEMP    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CalWidth-1:0] sens_coef;
      logic [CalWidth-1:0] offset_coef;
      logic [CalWidth-1:0] sens_temp_coef;
      logic [CalWidth-1:0] offset_temp_coef;
      logic [CalWidth-1:0] ref_temp_coef;
      logic [CalWidth-1:0] temp_slope_coef;
   } cal_type;

   typedef struct packed {
      logic [RawWidth-1:0] pressure_raw;
      logic [RawWidth-1:0] temperature_raw;
   } req_type;

   typedef struct packed {
      logic signed [TempOutWidth-1:0] temperature_centi;
      logic signed [PresOutWidth-1:0] pressure_centi;
   } rsp_type;

   // Per-stage load enables, stage 1 at the input
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
      logic en4;
      logic en5;
      logic en6;
   } pipe_ctl_type;

endpackage

>>> rtl/bfoc_coef.sv
// ----------------------------------------------------------------------------
// bfoc_coef
// Stages 1-3: temperature delta, coefficient products, OFF / SENS / TEMP.
// ----------------------------------------------------------------------------
module bfoc_coef (
   input  logic                                  clock,
   input  bfoc_pkg::pipe_ctl_type                ctl,
   input  bfoc_pkg::cal_type                     cal,
   input  bfoc_pkg::req_type                     req,
   output logic [bfoc_pkg::RawWidth-1:0]         pres_raw,
   output logic signed [bfoc_pkg::SensWidth-1:0] sens,
   output logic signed [bfoc_pkg::OffWidth-1:0]  off,
   output logic [bfoc_pkg::TempOutWidth-1:0]     temp
);
   import bfoc_pkg::*;

   // stage 1
   logic signed [DtWidth-1:0]     dt_ff, dt_in;
   logic [RawWidth-1:0]           p1_ff;
   // stage 2
   logic signed [TcProdWidth-1:0] off_prod_ff, off_prod_in;
   logic signed [TcProdWidth-1:0] sens_prod_ff, sens_prod_in;
   logic signed [TcProdWidth-1:0] temp_prod_ff, temp_prod_in;
   logic [RawWidth-1:0]           p2_ff;
   // stage 3
   logic signed [OffWidth-1:0]    off_ff, off_in;
   logic signed [SensWidth-1:0]   sens_ff, sens_in;
   logic [TempOutWidth-1:0]       temp_ff, temp_in;
   logic signed [TempOutWidth+1:0] temp_full;
   logic [RawWidth-1:0]           p3_ff;

   // dT = D2 - Tref * 2^8, always fits 25 bits signed
   assign dt_in = $signed({1'b0, req.temperature_raw})
                - $signed({1'b0, cal.ref_temp_coef, {RefShift{1'b0}}});

   assign off_prod_in  = dt_ff * $signed({1'b0, cal.offset_temp_coef});
   assign sens_prod_in = dt_ff * $signed({1'b0, cal.sens_temp_coef});
   assign temp_prod_in = dt_ff * $signed({1'b0, cal.temp_slope_coef});

   // >>> on signed values floors toward minus infinity
   assign off_in  = $signed({4'b0, cal.offset_coef, {OffShift{1'b0}}})
                  + OffWidth'(off_prod_ff >>> OffTcShift);
   assign sens_in = $signed({4'b0, cal.sens_coef, {SensShift{1'b0}}})
                  + SensWidth'(sens_prod_ff >>> SensTcShift);
   assign temp_full = (TempOutWidth+2)'(temp_prod_ff >>> TempShift)
                    + (TempOutWidth+2)'(TempBase);
   // out-of-range temperature wraps to the low bits
   assign temp_in = temp_full[TempOutWidth-1:0];

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         dt_ff <= dt_in;
         p1_ff <= req.pressure_raw;
      end
      if (ctl.en2) begin
         off_prod_ff  <= off_prod_in;
         sens_prod_ff <= sens_prod_in;
         temp_prod_ff <= temp_prod_in;
         p2_ff        <= p1_ff;
      end
      if (ctl.en3) begin
         off_ff  <= off_in;
         sens_ff <= sens_in;
         temp_ff <= temp_in;
         p3_ff   <= p2_ff;
      end
   end

   assign pres_raw = p3_ff;
   assign sens     = sens_ff;
   assign off      = off_ff;
   assign temp     = temp_ff;

endmodule

>>> rtl/bfoc_pres.sv
// ----------------------------------------------------------------------------
// bfoc_pres
// Stages 4-6: split D1 * SENS product, scaling, offset removal.
// ----------------------------------------------------------------------------
module bfoc_pres (
   input  logic                                  clock,
   input  bfoc_pkg::pipe_ctl_type                ctl,
   input  logic [bfoc_pkg::RawWidth-1:0]         pres_raw,
   input  logic signed [bfoc_pkg::SensWidth-1:0] sens,
   input  logic signed [bfoc_pkg::OffWidth-1:0]  off,
   input  logic [bfoc_pkg::TempOutWidth-1:0]     temp,
   output bfoc_pkg::rsp_type                     rsp
);
   import bfoc_pkg::*;

   // stage 4: two partial products
   logic [PlWidth-1:0]            pl_ff, pl_in;
   logic signed [PhWidth-1:0]     ph_ff, ph_in;
   logic signed [OffWidth-1:0]    off4_ff;
   logic [TempOutWidth-1:0]       temp4_ff;
   // stage 5: recombine and scale
   logic signed [MulWidth-1:0]    mul;
   logic signed [ScaledWidth-1:0] scaled_ff, scaled_in;
   logic signed [OffWidth-1:0]    off5_ff;
   logic [TempOutWidth-1:0]       temp5_ff;
   // stage 6: result register
   logic signed [ScaledWidth:0]   diff;
   rsp_type                       rsp_ff, rsp_in;

   // low slice unsigned, high slice signed
   assign pl_in = pres_raw * sens[SensLoWidth-1:0];
   assign ph_in = $signed({1'b0, pres_raw}) * $signed(sens[SensWidth-1:SensLoWidth]);

   assign mul = $signed({ph_ff, {SensLoWidth{1'b0}}})
              + $signed({{(MulWidth-PlWidth){1'b0}}, pl_ff});
   assign scaled_in = ScaledWidth'(mul >>> ProdShift);

   assign diff = (ScaledWidth+1)'(scaled_ff) - (ScaledWidth+1)'(off5_ff);
   always_comb begin
      rsp_in.temperature_centi = $signed(temp5_ff);
      rsp_in.pressure_centi    = PresOutWidth'(diff >>> PresShift);
   end

   always_ff @(posedge clock) begin
      if (ctl.en4) begin
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         off4_ff  <= off;
         temp4_ff <= temp;
      end
      if (ctl.en5) begin
         scaled_ff <= scaled_in;
         off5_ff   <= off4_ff;
         temp5_ff  <= temp4_ff;
      end
      if (ctl.en6) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> rtl/baro_first_order_compensation.sv
// ----------------------------------------------------------------------------
// baro_first_order_compensation
// First-order temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Six-stage pipeline that takes one beat of raw pressure/temperature per clock
// while req_stall is low and returns compensated temperature (0.01 degC) and
// pressure (0.01 mbar), one result beat per input beat. Throughput is one
// beat per cycle while rsp_stall is low. The six register stages are delta,
// coefficient products, OFF/SENS/TEMP sums, split D1*SENS partial products,
// product recombine and 2^21 scaling, and offset removal and 2^15 scaling,
// which is also the output register. Backpressure on rsp_stall ripples back
// stage by stage; empty stages keep filling, so req_stall only rises once
// every stage holds a beat. Calibration words are written through the csr_
// port, indexes 0..5 in PROM word order; other indexes are ignored. Write
// them only while no beat is in flight. Temperatures beyond the 18-bit range
// wrap; pressure never saturates.
// ----------------------------------------------------------------------------
module baro_first_order_compensation (
   input  logic                                    clock,
   input  logic                                    reset,
   // input beats
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  bfoc_pkg::req_type                       req_payload,
   // result beats
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output bfoc_pkg::rsp_type                       rsp_payload,
   // calibration writes
   input  logic                                    csr_wr_en,
   input  logic [bfoc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [bfoc_pkg::CalWidth-1:0]           csr_wr_data
);
   import bfoc_pkg::*;

   localparam int Stages = 6;

   cal_type                     cal_ff, cal_in;
   logic [Stages-1:0]           valid_ff, valid_in;
   logic [Stages:0]             room;      // room[k]: stage k may load
   pipe_ctl_type                ctl;

   logic [RawWidth-1:0]         pres_raw;
   logic signed [SensWidth-1:0] sens;
   logic signed [OffWidth-1:0]  off;
   logic [TempOutWidth-1:0]     temp;

   // ---- calibration registers
   always_comb begin
      cal_in = cal_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SENS:        cal_in.sens_coef        = csr_wr_data;
            CSR_OFFSET:      cal_in.offset_coef      = csr_wr_data;
            CSR_SENS_TEMP:   cal_in.sens_temp_coef   = csr_wr_data;
            CSR_OFFSET_TEMP: cal_in.offset_temp_coef = csr_wr_data;
            CSR_REF_TEMP:    cal_in.ref_temp_coef    = csr_wr_data;
            CSR_TEMP_SLOPE:  cal_in.temp_slope_coef  = csr_wr_data;
            default:         cal_in = cal_ff;
         endcase
      end
   end

   // ---- pipeline flow control
   // A stage loads when it is empty or its beat moves on this cycle.
   always_comb begin
      room[Stages] = !rsp_stall;
      for (int k = Stages - 1; k >= 0; k--) begin
         room[k] = !valid_ff[k] || room[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int k = 0; k < Stages; k++) begin
         if (room[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_comb begin
      ctl.en1 = room[0];
      ctl.en2 = room[1];
      ctl.en3 = room[2];
      ctl.en4 = room[3];
      ctl.en5 = room[4];
      ctl.en6 = room[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff   <= '0;
         valid_ff <= '0;
      end else begin
         cal_ff   <= cal_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !room[0];
   assign rsp_valid = valid_ff[Stages-1];

   // ---- datapath
   bfoc_coef u_coef (
      .clock    (clock),
      .ctl      (ctl),
      .cal      (cal_ff),
      .req      (req_payload),
      .pres_raw (pres_raw),
      .sens     (sens),
      .off      (off),
      .temp     (temp)
   );

   bfoc_pres u_pres (
      .clock    (clock),
      .ctl      (ctl),
      .pres_raw (pres_raw),
      .sens     (sens),
      .off      (off),
      .temp     (temp),
      .rsp      (rsp_payload)
   );

   // ---- checks
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted beat did not enter stage 1");

   a_bubble_takes : assert property (@(posedge clock) disable iff (reset)
      (valid_ff != {Stages{1'b1}}) |-> !req_stall)
      else $error("input stalled with an empty stage");

   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      ((valid_ff == {Stages{1'b1}}) && rsp_stall) |-> req_stall)
      else $error("input taken while full and stalled");

   a_stage5_feeds : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[Stages-2] && !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("beat lost between last two stages");

endmodule
